// ----- sv/tgr_pkg.sv -----
// Shared types, constants and helpers of the text glyph renderer.
`timescale 1ns / 1ps

package tgr_pkg;

  // Default font geometry
  localparam int DEF_CHAR_WIDTH      = 8;
  localparam int DEF_CHAR_HEIGHT     = 8;
  localparam int DEF_LAST_GLYPH_CODE = 140;

  // Glyph store address, wide enough for the largest legal geometry
  localparam int GLYPH_ADDR_W = 13;

  // Depth of the queue between front and back
  localparam int CMD_DEPTH = 2;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic signed [12:0] CURSOR_MAX = 13'sd2047;

  // Item function codes
  localparam logic FUNC_DRAW = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_WRAP_ENABLE = 2'd0;
  localparam logic [1:0] CFG_X_LIMIT     = 2'd1;
  localparam logic [1:0] CFG_Y_LIMIT     = 2'd2;
  localparam logic [1:0] CFG_TRANSP      = 2'd3;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_SKIP,
    CMD_DRAW
  } cmd_kind_e;

  typedef struct packed {
    logic        wrap_enable;
    logic [10:0] x_limit;
    logic [10:0] y_limit;
    logic [31:0] transparent_color;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e               kind;
    logic [GLYPH_ADDR_W-1:0] addr;   // glyph row to write, or first glyph row
    logic [7:0]              bits;   // row bits for a load
    logic signed [11:0]      x;
    logic signed [11:0]      y;
    logic [31:0]             fg;
    logic [31:0]             bg;
    logic [15:0]             count;
  } cmd_t;

  // Cursor advance, saturating at the top of the cursor range
  function automatic logic signed [11:0] tgr_sat_add(logic signed [11:0] a,
                                                     logic [4:0] step);
    logic signed [12:0] s;
    s = {a[11], a} + {8'd0, step};
    return (s > CURSOR_MAX) ? CURSOR_MAX[11:0] : s[11:0];
  endfunction

endpackage

// ----- sv/text_glyph_renderer.sv -----
// Top level of the text glyph renderer: configuration registers, front, queue, back.
`timescale 1ns / 1ps

// Usage
//   Input queue: drive the item fields and raise push; a beat is taken on a
//   clock edge with push high and full low. func 1 loads one glyph row
//   (no result), func 0 draws one character at the text cursor.
//   Result queue: while empty is low the oldest pixel beat sits on the result
//   ports; pop with empty low takes it. A drawn character gives
//   CHAR_WIDTH*CHAR_HEIGHT beats (64 by default), row by row, leftmost first;
//   a skipped character (newline, clipped, negative) gives one beat with
//   write 0. last marks the final beat of each character.
//   Config: cfg_we_i writes register cfg_idx_i at once (0 wrap enable,
//   1 x limit, 2 y limit, 3 transparent colour). Write only while idle.
// Timing
//   The front updates the cursor in the accept cycle and queues a command.
//   The back reads the first glyph row and loads it in ST_FIRST, then gives
//   one beat per cycle while the output register is free, fetching the next
//   row from the glyph store while the current one is shifted out. A row load
//   or skip is handled in ST_IDLE; a skip waits for a free output register.
//   A stalled receiver holds the output register; the queue then fills and
//   full rises. Reset clears cursor, saved cursor, count and config; the
//   glyph store holds nothing valid until loaded.

module text_glyph_renderer #(
  parameter int CHAR_WIDTH      = tgr_pkg::DEF_CHAR_WIDTH,
  parameter int CHAR_HEIGHT     = tgr_pkg::DEF_CHAR_HEIGHT,
  parameter int LAST_GLYPH_CODE = tgr_pkg::DEF_LAST_GLYPH_CODE
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic               func_i,
  input  logic [7:0]         code_i,
  input  logic               first_char_i,
  input  logic               last_char_i,
  input  logic               use_saved_i,
  input  logic signed [11:0] start_x_i,
  input  logic signed [11:0] start_y_i,
  input  logic [31:0]        fg_color_i,
  input  logic [31:0]        bg_color_i,
  input  logic [10:0]        row_index_i,
  input  logic [7:0]         row_bits_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [11:0] pix_x_o,
  output logic signed [11:0] pix_y_o,
  output logic [31:0]        color_o,
  output logic               write_o,
  output logic               last_o,
  output logic [15:0]        char_count_o
);
  import tgr_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_pop, cmd_empty;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wrap_enable       <= 1'b0;
      cfg_q.x_limit           <= 11'd472;
      cfg_q.y_limit           <= 11'd264;
      cfg_q.transparent_color <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WRAP_ENABLE: cfg_q.wrap_enable       <= cfg_wdata_i[0];
        CFG_X_LIMIT:     cfg_q.x_limit           <= cfg_wdata_i[10:0];
        CFG_Y_LIMIT:     cfg_q.y_limit           <= cfg_wdata_i[10:0];
        CFG_TRANSP:      cfg_q.transparent_color <= cfg_wdata_i;
        default:         cfg_q                   <= cfg_q;
      endcase
    end
  end

  tgr_front #(
    .CHAR_WIDTH      (CHAR_WIDTH),
    .CHAR_HEIGHT     (CHAR_HEIGHT),
    .LAST_GLYPH_CODE (LAST_GLYPH_CODE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .full_i       (full),
    .func_i       (func_i),
    .code_i       (code_i),
    .first_char_i (first_char_i),
    .last_char_i  (last_char_i),
    .use_saved_i  (use_saved_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .fg_color_i   (fg_color_i),
    .bg_color_i   (bg_color_i),
    .row_index_i  (row_index_i),
    .row_bits_i   (row_bits_i),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  // Commands (row loads included, so loads stay ordered with draws)
  tgr_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_push),
    .wr_data_i (cmd_in),
    .full_o    (full),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_out),
    .empty_o   (cmd_empty)
  );

  tgr_back #(
    .CHAR_WIDTH      (CHAR_WIDTH),
    .CHAR_HEIGHT     (CHAR_HEIGHT),
    .LAST_GLYPH_CODE (LAST_GLYPH_CODE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_empty_i  (cmd_empty),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (cmd_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .pix_x_o      (pix_x_o),
    .pix_y_o      (pix_y_o),
    .color_o      (color_o),
    .write_o      (write_o),
    .last_o       (last_o),
    .char_count_o (char_count_o)
  );

  // Every beat belongs to a counted character
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> char_count_o != 16'd0)
    else $error("result beat with zero character count");

  // Pixels of one character stream without bubbles
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> !empty)
    else $error("gap inside a character");

  // Successive pixels step along the row or down to the next row
  a_pixel_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=>
      (pix_x_o == $past(pix_x_o) + 12'sd1) || (pix_y_o == $past(pix_y_o) + 12'sd1))
    else $error("pixel coordinate jump inside a character");

endmodule

// ----- sv/tgr_fifo.sv -----
// Short command queue between the front and the back of the renderer.
`timescale 1ns / 1ps

module tgr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  tgr_pkg::cmd_t  wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output tgr_pkg::cmd_t  rd_data_o,
  output logic           empty_o
);
  import tgr_pkg::*;

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             ent_q [CMD_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CNT_W'(CMD_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      ent_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/tgr_front.sv -----
// Front end: accepts items, runs the text cursor and classifies each item.
`timescale 1ns / 1ps

module tgr_front #(
  parameter int CHAR_WIDTH      = tgr_pkg::DEF_CHAR_WIDTH,
  parameter int CHAR_HEIGHT     = tgr_pkg::DEF_CHAR_HEIGHT,
  parameter int LAST_GLYPH_CODE = tgr_pkg::DEF_LAST_GLYPH_CODE
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tgr_pkg::cfg_t      cfg_i,
  input  logic               push_i,
  input  logic               full_i,
  input  logic               func_i,
  input  logic [7:0]         code_i,
  input  logic               first_char_i,
  input  logic               last_char_i,
  input  logic               use_saved_i,
  input  logic signed [11:0] start_x_i,
  input  logic signed [11:0] start_y_i,
  input  logic [31:0]        fg_color_i,
  input  logic [31:0]        bg_color_i,
  input  logic [10:0]        row_index_i,
  input  logic [7:0]         row_bits_i,
  output logic               cmd_push_o,
  output tgr_pkg::cmd_t      cmd_o
);
  import tgr_pkg::*;

  localparam int GLYPH_DEPTH   = (LAST_GLYPH_CODE + 2) * CHAR_HEIGHT;
  localparam int FALLBACK_BASE = (LAST_GLYPH_CODE + 1) * CHAR_HEIGHT;

  logic signed [11:0] cur_x_q, cur_y_q, sav_x_q, sav_y_q;
  logic [15:0]        cnt_q;
  logic               uses_q;

  logic signed [11:0] cx, cy, org_x, org_y, xl, yl;
  logic [15:0]        cnt;
  logic               uses, nl, skip, accept, load_ok;
  logic [GLYPH_ADDR_W-1:0] base;

  assign accept  = push_i && !full_i;
  assign xl      = {1'b0, cfg_i.x_limit};
  assign yl      = {1'b0, cfg_i.y_limit};
  assign load_ok = (32'(row_index_i) < GLYPH_DEPTH);
  assign nl      = (code_i == NEWLINE_CODE);

  always_comb begin
    uses = uses_q;
    cx   = cur_x_q;
    cy   = cur_y_q;
    cnt  = cnt_q;
    if (first_char_i) begin
      uses = use_saved_i;
      cx   = use_saved_i ? sav_x_q : start_x_i;
      cy   = use_saved_i ? sav_y_q : start_y_i;
      cnt  = '0;
    end
    if (cnt != COUNT_MAX) begin
      cnt = cnt + 16'd1;
    end
    if ((cfg_i.wrap_enable && cx > xl) || nl) begin
      cy = tgr_sat_add(cy, 5'(CHAR_HEIGHT));
      cx = '0;
    end
    if (cfg_i.wrap_enable && cy > yl) begin
      cy = '0;
    end
    skip = nl || (!cfg_i.wrap_enable && (cx > xl || cy > yl)) || cx[11] || cy[11];
    org_x = cx;
    org_y = cy;
    if (!skip) begin
      cx = tgr_sat_add(cx, 5'(CHAR_WIDTH));
    end
  end

  // Glyph base row: loaded glyph, or the fallback glyph above the last code
  assign base = (32'(code_i) <= LAST_GLYPH_CODE) ?
                GLYPH_ADDR_W'(code_i) * GLYPH_ADDR_W'(CHAR_HEIGHT) :
                GLYPH_ADDR_W'(FALLBACK_BASE);

  always_comb begin
    cmd_o       = '0;
    cmd_o.fg    = fg_color_i;
    cmd_o.bg    = bg_color_i;
    cmd_o.count = cnt;
    cmd_o.x     = org_x;
    cmd_o.y     = org_y;
    if (func_i == FUNC_LOAD) begin
      cmd_o.kind = CMD_LOAD;
      cmd_o.addr = GLYPH_ADDR_W'(row_index_i);
      cmd_o.bits = row_bits_i;
    end else if (skip) begin
      cmd_o.kind = CMD_SKIP;
    end else begin
      cmd_o.kind = CMD_DRAW;
      cmd_o.addr = base;
    end
  end

  // Out-of-range row loads are dropped here
  assign cmd_push_o = accept && ((func_i == FUNC_DRAW) || load_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      sav_x_q <= '0;
      sav_y_q <= '0;
      cnt_q   <= '0;
      uses_q  <= 1'b0;
    end else if (accept && func_i == FUNC_DRAW) begin
      cur_x_q <= cx;
      cur_y_q <= cy;
      cnt_q   <= cnt;
      uses_q  <= uses;
      if (last_char_i && uses) begin
        sav_x_q <= cx;
        sav_y_q <= cy;
      end
    end
  end

endmodule

// ----- sv/tgr_back.sv -----
// Back end: glyph store, pixel sequencer and output register.
`timescale 1ns / 1ps

module tgr_back #(
  parameter int CHAR_WIDTH      = tgr_pkg::DEF_CHAR_WIDTH,
  parameter int CHAR_HEIGHT     = tgr_pkg::DEF_CHAR_HEIGHT,
  parameter int LAST_GLYPH_CODE = tgr_pkg::DEF_LAST_GLYPH_CODE
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tgr_pkg::cfg_t      cfg_i,
  input  logic               cmd_empty_i,
  input  tgr_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic signed [11:0] pix_x_o,
  output logic signed [11:0] pix_y_o,
  output logic [31:0]        color_o,
  output logic               write_o,
  output logic               last_o,
  output logic [15:0]        char_count_o
);
  import tgr_pkg::*;

  localparam int GLYPH_DEPTH = (LAST_GLYPH_CODE + 2) * CHAR_HEIGHT;
  localparam int ADDR_W      = $clog2(GLYPH_DEPTH);
  localparam int GX_W        = (CHAR_WIDTH > 1) ? $clog2(CHAR_WIDTH) : 1;
  localparam int GY_W        = (CHAR_HEIGHT > 1) ? $clog2(CHAR_HEIGHT) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_EMIT
  } state_e;

  logic [7:0] glyph_mem [GLYPH_DEPTH];
  logic [7:0] rd_q;

  state_e                  state_q;
  logic [GX_W-1:0]         gx_q;
  logic [GY_W-1:0]         gy_q;
  logic [7:0]              row_q;
  logic signed [11:0]      px_q, py_q, org_x_q;
  logic [31:0]             fg_q, bg_q;
  logic [15:0]             cnt_q;
  logic [GLYPH_ADDR_W-1:0] addr_q;

  logic                    out_valid_q;
  logic signed [11:0]      out_x_q, out_y_q;
  logic [31:0]             out_color_q;
  logic                    out_write_q, out_last_q;
  logic [15:0]             out_cnt_q;

  logic                    out_free, emit, row_end, char_end, rd_en, mem_we;
  logic [GLYPH_ADDR_W-1:0] rd_addr;
  logic [31:0]             pix_color;

  assign out_free  = !out_valid_q || pop_i;
  assign emit      = (state_q == ST_EMIT) && out_free;
  assign row_end   = (gx_q == GX_W'(CHAR_WIDTH - 1));
  assign char_end  = (gy_q == GY_W'(CHAR_HEIGHT - 1));
  assign pix_color = row_q[7] ? fg_q : bg_q;

  always_comb begin
    cmd_pop_o = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = addr_q;
    mem_we    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.kind)
            CMD_LOAD: begin
              cmd_pop_o = 1'b1;
              mem_we    = 1'b1;
            end
            CMD_SKIP: cmd_pop_o = out_free;
            CMD_DRAW: begin
              cmd_pop_o = 1'b1;
              rd_en     = 1'b1;
              rd_addr   = cmd_i.addr;
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      ST_FIRST: rd_en = (CHAR_HEIGHT > 1);
      ST_EMIT:  rd_en = emit && row_end && !char_end && (32'(gy_q) + 2 < CHAR_HEIGHT);
      default:  rd_en = 1'b0;
    endcase
  end

  // Glyph store: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      glyph_mem[cmd_i.addr[ADDR_W-1:0]] <= cmd_i.bits;
    end
    if (rd_en) begin
      rd_q <= glyph_mem[rd_addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gx_q        <= '0;
      gy_q        <= '0;
      row_q       <= '0;
      px_q        <= '0;
      py_q        <= '0;
      org_x_q     <= '0;
      fg_q        <= '0;
      bg_q        <= '0;
      cnt_q       <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_color_q <= '0;
      out_write_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_cnt_q   <= '0;
    end else begin
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      if (rd_en && state_q != ST_IDLE) begin
        addr_q <= addr_q + 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o && cmd_i.kind == CMD_SKIP) begin
            out_valid_q <= 1'b1;
            out_x_q     <= '0;
            out_y_q     <= '0;
            out_color_q <= '0;
            out_write_q <= 1'b0;
            out_last_q  <= 1'b1;
            out_cnt_q   <= cmd_i.count;
          end
          if (cmd_pop_o && cmd_i.kind == CMD_DRAW) begin
            addr_q  <= cmd_i.addr + 1'b1;
            org_x_q <= cmd_i.x;
            px_q    <= cmd_i.x;
            py_q    <= cmd_i.y;
            fg_q    <= cmd_i.fg;
            bg_q    <= cmd_i.bg;
            cnt_q   <= cmd_i.count;
            gx_q    <= '0;
            gy_q    <= '0;
            state_q <= ST_FIRST;
          end
        end
        ST_FIRST: begin
          row_q   <= rd_q;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            out_x_q     <= px_q;
            out_y_q     <= py_q;
            out_color_q <= pix_color;
            out_write_q <= (pix_color != cfg_i.transparent_color);
            out_last_q  <= row_end && char_end;
            out_cnt_q   <= cnt_q;
            if (row_end) begin
              gx_q <= '0;
              px_q <= org_x_q;
              if (char_end) begin
                state_q <= ST_IDLE;
              end else begin
                gy_q  <= gy_q + 1'b1;
                py_q  <= py_q + 12'sd1;
                row_q <= rd_q;
              end
            end else begin
              gx_q  <= gx_q + 1'b1;
              px_q  <= px_q + 12'sd1;
              row_q <= {row_q[6:0], 1'b0};
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign empty_o      = !out_valid_q;
  assign pix_x_o      = out_x_q;
  assign pix_y_o      = out_y_q;
  assign color_o      = out_color_q;
  assign write_o      = out_write_q;
  assign last_o       = out_last_q;
  assign char_count_o = out_cnt_q;

endmodule
